// ===== design/wsdf_pkg.sv =====
`default_nettype none

package wsdf_pkg;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd16777216;
  localparam logic [6:0]  LEN_CODE_16     = 7'd126;
  localparam logic [6:0]  LEN_CODE_64     = 7'd127;
  localparam logic [3:0]  EXT_BYTES_16    = 4'd2;
  localparam logic [3:0]  EXT_BYTES_64    = 4'd8;
  localparam logic [3:0]  KEY_BYTES       = 4'd4;
  localparam logic [3:0]  BASE_BYTES      = 4'd2;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [31:0] length;
    logic [7:0]  payload_byte;
    logic        frame_end;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  function automatic logic [3:0] ext_bytes(input logic [6:0] code);
    logic [3:0] n;
    n = 4'd0;
    if (code == LEN_CODE_16) n = EXT_BYTES_16;
    else if (code == LEN_CODE_64) n = EXT_BYTES_64;
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/wsdf_parser.sv =====
`default_nettype none

module wsdf_parser
  import wsdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] max_payload,
  output push_t            push
);

  logic [3:0]  step_r, step_nxt;
  logic        in_payload_r, in_payload_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [6:0]  code_r, code_nxt;
  logic [31:0] len_lo_r, len_lo_nxt;
  logic        len_hi_r, len_hi_nxt;   // any of bits 63..32 set
  logic [31:0] key_r, key_nxt;
  logic [31:0] left_r, left_nxt;
  logic [1:0]  midx_r, midx_nxt;
  logic        failed_r, failed_nxt;

  logic [7:0]  key_byte;
  logic [3:0]  total;
  logic [3:0]  step_inc;

  always_comb begin
    step_nxt       = step_r;
    in_payload_nxt = in_payload_r;
    fin_nxt        = fin_r;
    opcode_nxt     = opcode_r;
    masked_nxt     = masked_r;
    code_nxt       = code_r;
    len_lo_nxt     = len_lo_r;
    len_hi_nxt     = len_hi_r;
    key_nxt        = key_r;
    left_nxt       = left_r;
    midx_nxt       = midx_r;
    failed_nxt     = failed_r;
    key_byte       = 8'd0;
    total          = 4'd0;
    step_inc       = step_r + 4'd1;

    push                  = '0;
    push.res.kind         = KIND_HEADER;

    if (failed_r) begin
      // sticky error: drop everything
    end else if (in_payload_r) begin
      case (midx_r)
        2'd0:    key_byte = key_r[31:24];
        2'd1:    key_byte = key_r[23:16];
        2'd2:    key_byte = key_r[15:8];
        default: key_byte = key_r[7:0];
      endcase
      if (!masked_r) key_byte = 8'd0;
      midx_nxt = midx_r + 2'd1;
      left_nxt = left_r - 32'd1;
      push.valid            = 1'b1;
      push.res.kind         = KIND_DATA;
      push.res.payload_byte = data_byte ^ key_byte;
      push.res.frame_end    = (left_r == 32'd1);
      if (left_r == 32'd1) begin
        in_payload_nxt = 1'b0;
        step_nxt       = 4'd0;
        midx_nxt       = 2'd0;
      end
    end else if (step_r == 4'd0) begin
      fin_nxt    = data_byte[7];
      opcode_nxt = data_byte[3:0];
      step_nxt   = 4'd1;
    end else begin
      if (step_r == 4'd1) begin
        masked_nxt = data_byte[7];
        code_nxt   = data_byte[6:0];
        len_lo_nxt = (data_byte[6:0] < LEN_CODE_16) ? {25'd0, data_byte[6:0]} : 32'd0;
        len_hi_nxt = 1'b0;
        key_nxt    = 32'd0;
      end else if (step_r < BASE_BYTES + ext_bytes(code_r)) begin
        len_lo_nxt = {len_lo_r[23:0], data_byte};
        len_hi_nxt = len_hi_r | (len_lo_r[31:24] != 8'd0);
      end else begin
        key_nxt = {key_r[23:0], data_byte};
      end

      total = BASE_BYTES + ext_bytes(code_nxt) + (masked_nxt ? KEY_BYTES : 4'd0);
      if (step_inc < total) begin
        step_nxt = step_inc;
      end else begin
        step_nxt = 4'd0;
        if (len_hi_nxt || (len_lo_nxt > max_payload)) begin
          failed_nxt         = 1'b1;
          push.valid         = 1'b1;
          push.res.kind      = KIND_ERROR;
        end else begin
          left_nxt           = len_lo_nxt;
          midx_nxt           = 2'd0;
          in_payload_nxt     = (len_lo_nxt != 32'd0);
          push.valid         = 1'b1;
          push.res.kind      = KIND_HEADER;
          push.res.frame_end = (len_lo_nxt == 32'd0);
        end
      end
    end

    push.res.fin    = fin_nxt;
    push.res.opcode = opcode_nxt;
    push.res.masked = masked_nxt;
    push.res.length = len_hi_nxt ? 32'hFFFF_FFFF : len_lo_nxt;
    push.valid      = push.valid & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= '0;
      in_payload_r <= 1'b0;
      fin_r        <= 1'b0;
      opcode_r     <= '0;
      masked_r     <= 1'b0;
      code_r       <= '0;
      len_lo_r     <= '0;
      len_hi_r     <= 1'b0;
      key_r        <= '0;
      left_r       <= '0;
      midx_r       <= '0;
      failed_r     <= 1'b0;
    end else if (accept) begin
      step_r       <= step_nxt;
      in_payload_r <= in_payload_nxt;
      fin_r        <= fin_nxt;
      opcode_r     <= opcode_nxt;
      masked_r     <= masked_nxt;
      code_r       <= code_nxt;
      len_lo_r     <= len_lo_nxt;
      len_hi_r     <= len_hi_nxt;
      key_r        <= key_nxt;
      left_r       <= left_nxt;
      midx_r       <= midx_nxt;
      failed_r     <= failed_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/wsdf_out_buf.sv =====
`default_nettype none

module wsdf_out_buf
  import wsdf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       full,
  output logic       out_valid,
  input  wire logic  out_stall,
  output res_t       out_res
);

  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  logic pop;

  assign pop = main_v_r & ~out_stall;

  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = 1'b0;
      end
    end
    if (push.valid) begin
      if (!main_v_nxt) begin
        main_nxt   = push.res;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push.res;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

endmodule

`default_nettype wire

// ===== design/websocket_frame_deframer_top.sv =====
// Results are registered in a two-entry output buffer that absorbs one stalled request.
// Throughput: one byte per cycle while in_stall is low.
// in_stall rises only when both output entries are full.
// Reset (rst_n low, synchronous): parser back to the first header byte, buffer empty,
// error flag cleared, max_payload back to 16777216.
`default_nettype none

module websocket_frame_deframer_top
  import wsdf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_max_payload,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic             out_fin,
  output logic [3:0]       out_opcode,
  output logic             out_masked,
  output logic [31:0]      out_payload_length,
  output logic [7:0]       out_payload_byte,
  output logic             out_frame_end
);

  logic [31:0] max_payload_r;
  logic        accept;
  logic        full;
  push_t       push;
  res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid & ~full;

  wsdf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .max_payload (max_payload_r),
    .push        (push)
  );

  wsdf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_result_kind    = res.kind;
  assign out_fin            = res.fin;
  assign out_opcode         = res.opcode;
  assign out_masked         = res.masked;
  assign out_payload_length = res.length;
  assign out_payload_byte   = res.payload_byte;
  assign out_frame_end      = res.frame_end;

endmodule

`default_nettype wire

// ===== design/wsdf_checker.sv =====
`default_nettype none

module wsdf_checker
  import wsdf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_result_kind,
  input wire logic [31:0] out_payload_length,
  input wire logic [7:0]  out_payload_byte,
  input wire logic        out_frame_end
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_result_kind)
                                 && $stable(out_payload_byte))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_result_kind != 2'd3)
    else $error("bad result kind");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_stall && out_result_kind == KIND_ERROR |=> !out_valid)
    else $error("result after length error");

  a_empty_hdr: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_result_kind == KIND_HEADER
      |-> out_frame_end == (out_payload_length == 32'd0))
    else $error("header end flag disagrees with length");

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_result_kind    (out_result_kind),
  .out_payload_length (out_payload_length),
  .out_payload_byte   (out_payload_byte),
  .out_frame_end      (out_frame_end)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;
  import wsdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    res_t       want;
  } row_t;

  localparam res_t NONE = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_max_payload = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic        out_fin;
  logic [3:0]  out_opcode;
  logic        out_masked;
  logic [31:0] out_payload_length;
  logic [7:0]  out_payload_byte;
  logic        out_frame_end;

  websocket_frame_deframer_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_payload   (cfg_max_payload),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_fin           (out_fin),
    .out_opcode        (out_opcode),
    .out_masked        (out_masked),
    .out_payload_length(out_payload_length),
    .out_payload_byte  (out_payload_byte),
    .out_frame_end     (out_frame_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // deframer shadow state
  logic [3:0]  hdr_step;
  logic        pay_active;
  logic        cur_fin;
  logic [3:0]  cur_op;
  logic        cur_masked;
  logic [6:0]  len_code;
  logic [63:0] len_sum;
  logic [31:0] mask_word;
  logic [31:0] pay_left;
  logic [1:0]  key_pos;
  logic        stream_dead;
  logic [31:0] max_len_cfg;

  res_t        want_q[$];
  row_t        tab[$];

  int unsigned sent;
  int unsigned frames;
  int unsigned checked;
  int unsigned fail_cnt;
  int unsigned shown;
  bit          gappy;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;

  function automatic res_t frame_res(input kind_t k, input logic [7:0] pb, input logic fe);
    res_t r;
    r.kind         = k;
    r.fin          = cur_fin;
    r.opcode       = cur_op;
    r.masked       = cur_masked;
    r.length       = (len_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len_sum[31:0];
    r.payload_byte = pb;
    r.frame_end    = fe;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, output bit got, output res_t r);
    logic [3:0] ext;
    logic [4:0] total;
    logic [4:0] s;
    logic [7:0] k;
    got = 1'b0;
    r = NONE;
    if (stream_dead) return;
    if (pay_active) begin
      k = cur_masked ? mask_word[(31 - 8 * key_pos) -: 8] : 8'h00;
      key_pos = key_pos + 2'd1;
      pay_left = pay_left - 32'd1;
      r = frame_res(KIND_DATA, b ^ k, pay_left == 32'd0);
      if (pay_left == 32'd0) begin
        pay_active = 1'b0;
        hdr_step = 4'd0;
        key_pos = 2'd0;
      end
      got = 1'b1;
      return;
    end
    if (hdr_step == 4'd0) begin
      cur_fin = b[7];
      cur_op = b[3:0];
      hdr_step = 4'd1;
      return;
    end
    ext = (len_code == LEN_CODE_16) ? EXT_BYTES_16 :
          (len_code == LEN_CODE_64) ? EXT_BYTES_64 : 4'd0;
    if (hdr_step == 4'd1) begin
      cur_masked = b[7];
      len_code = b[6:0];
      len_sum = (b[6:0] < LEN_CODE_16) ? 64'(b[6:0]) : 64'd0;
      mask_word = 32'd0;
      ext = (len_code == LEN_CODE_16) ? EXT_BYTES_16 :
            (len_code == LEN_CODE_64) ? EXT_BYTES_64 : 4'd0;
    end else if (hdr_step < BASE_BYTES + ext) begin
      len_sum = {len_sum[55:0], b};
    end else begin
      mask_word = {mask_word[23:0], b};
    end
    total = 5'(BASE_BYTES) + 5'(ext) + (cur_masked ? 5'(KEY_BYTES) : 5'd0);
    s = 5'(hdr_step) + 5'd1;
    if (s < total) begin
      hdr_step = s[3:0];
      return;
    end
    hdr_step = 4'd0;
    got = 1'b1;
    if (len_sum > 64'(max_len_cfg)) begin
      stream_dead = 1'b1;
      r = frame_res(KIND_ERROR, 8'h00, 1'b0);
      return;
    end
    pay_left = len_sum[31:0];
    key_pos = 2'd0;
    pay_active = (pay_left != 32'd0);
    r = frame_res(KIND_HEADER, 8'h00, pay_left == 32'd0);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    bit   got;
    res_t r;
    if (gappy && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    deframe_byte(b, got, r);
    if (got) want_q.push_back(typed ? want : r);
    sent++;
  endtask

  task automatic walk_tab();
    gappy = $urandom_range(0, 1);
    foreach (tab[i]) send_byte(tab[i].b, tab[i].typed, tab[i].want);
  endtask

  function automatic row_t row(input logic [7:0] b, input bit typed, input res_t want);
    row_t t;
    t.b = b;
    t.typed = typed;
    t.want = want;
    return t;
  endfunction

  task automatic send_frame(input logic [31:0] lim, input bit empty_only);
    int unsigned cap;
    int unsigned len;
    int unsigned enc;
    logic        msk;
    logic [31:0] key;
    logic [6:0]  code;
    cap = (lim > 300) ? 300 : lim;
    if (empty_only) len = 0;
    else begin
      case ($urandom_range(0, 9))
        0: len = (lim > 300) ? 125 : lim;
        1: len = $urandom_range(0, cap);
        default: len = $urandom_range(0, (cap < 20) ? cap : 20);
      endcase
    end
    enc = $urandom_range(0, 2);
    if (len > 125 && enc == 0) enc = $urandom_range(1, 2);
    code = (enc == 0) ? 7'(len) : (enc == 1) ? LEN_CODE_16 : LEN_CODE_64;
    msk = $urandom_range(0, 1);
    key = $urandom;
    gappy = $urandom_range(0, 1);
    send_byte({1'($urandom), 3'($urandom), 4'($urandom)}, 1'b0, NONE);
    send_byte({msk, code}, 1'b0, NONE);
    if (enc == 1) begin
      send_byte(8'(len >> 8), 1'b0, NONE);
      send_byte(8'(len), 1'b0, NONE);
    end else if (enc == 2) begin
      for (int i = 7; i >= 0; i--) send_byte(8'(64'(len) >> (8 * i)), 1'b0, NONE);
    end
    if (msk) for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8], 1'b0, NONE);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), 1'b0, NONE);
    frames++;
  endtask

  task automatic write_max(input logic [31:0] v);
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_payload <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_len_cfg = v;
  endtask

  // result checker
  always @(posedge clk) begin
    res_t act;
    res_t exp;
    if (rst_n && out_valid && !out_stall) begin
      act = {out_result_kind, out_fin, out_opcode, out_masked, out_payload_length,
             out_payload_byte, out_frame_end};
      if (want_q.size() == 0) begin
        fail_cnt++;
        if (shown < 10) begin
          shown++;
          $display("unexpected request: kind=%0d len=%h byte=%h", act.kind, act.length,
                   act.payload_byte);
        end
      end else begin
        exp = want_q.pop_front();
        checked++;
        if (act !== exp) begin
          fail_cnt++;
          if (shown < 10) begin
            shown++;
            $display("mismatch exp: kind=%0d fin=%0b op=%h mask=%0b len=%h byte=%h end=%0b",
                     exp.kind, exp.fin, exp.opcode, exp.masked, exp.length,
                     exp.payload_byte, exp.frame_end);
            $display("         act: kind=%0d fin=%0b op=%h mask=%0b len=%h byte=%h end=%0b",
                     act.kind, act.fin, act.opcode, act.masked, act.length,
                     act.payload_byte, act.frame_end);
          end
        end
      end
    end
  end

  // receiver backpressure
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;
  int unsigned mode_cnt = 64;
  bit          hold_taken = 1'b0;
  bit          rx_gappy = 1'b1;

  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (!calm && rx_gappy && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      burst_left = $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
    mode_cnt--;
    if (mode_cnt == 0) begin
      mode_cnt = 64;
      rx_gappy = $urandom_range(0, 1);
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned mark;
    int unsigned half;
    hdr_step = '0; pay_active = 1'b0; cur_fin = 1'b0; cur_op = '0; cur_masked = 1'b0;
    len_code = '0; len_sum = '0; mask_word = '0; pay_left = '0; key_pos = '0;
    stream_dead = 1'b0;
    max_len_cfg = MAX_PAYLOAD_RST;
    sent = 0; frames = 0; checked = 0; fail_cnt = 0; shown = 0; gappy = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty frame, masked 16-bit length, non-minimal 64-bit length
    tab.push_back(row(8'h81, 0, NONE));
    tab.push_back(row(8'h00, 1, {KIND_HEADER, 1'b1, 4'h1, 1'b0, 32'd0, 8'h00, 1'b1}));
    tab.push_back(row(8'h0A, 0, NONE));
    tab.push_back(row(8'hFE, 0, NONE));
    tab.push_back(row(8'h00, 0, NONE));
    tab.push_back(row(8'h01, 0, NONE));
    tab.push_back(row(8'h3C, 0, NONE));
    tab.push_back(row(8'hA5, 0, NONE));
    tab.push_back(row(8'h5A, 0, NONE));
    tab.push_back(row(8'hC3, 0, NONE));
    tab.push_back(row(8'h7E, 0, NONE));
    tab.push_back(row(8'h88, 0, NONE));
    tab.push_back(row(8'h7F, 0, NONE));
    for (int i = 0; i < 7; i++) tab.push_back(row(8'h00, 0, NONE));
    tab.push_back(row(8'h02, 1, {KIND_HEADER, 1'b1, 4'h8, 1'b0, 32'd2, 8'h00, 1'b0}));
    tab.push_back(row(8'hFF, 1, {KIND_DATA, 1'b1, 4'h8, 1'b0, 32'd2, 8'hFF, 1'b0}));
    tab.push_back(row(8'h00, 1, {KIND_DATA, 1'b1, 4'h8, 1'b0, 32'd2, 8'h00, 1'b1}));
    walk_tab();
    frames += 3;

    write_max(32'hFFFF_FFFF);
    hold_req <= 1'b1;
    mark = sent + 350;
    while (sent < mark) send_frame(max_len_cfg, 1'b0);

    write_max(32'd0);
    mark = sent + 60;
    while (sent < mark) send_frame(max_len_cfg, 1'b1);

    write_max($urandom_range(1, 40));
    half = sent + 160;
    mark = sent + 320;
    while (sent < mark) begin
      if (sent > half) calm <= 1'b1;
      send_frame(max_len_cfg, 1'b0);
    end

    write_max(32'd100);
    repeat (3) send_frame(max_len_cfg, 1'b0);

    // top bit of 64-bit length set: oversize, length saturates, stream dead after
    tab.delete();
    tab.push_back(row(8'h81, 0, NONE));
    tab.push_back(row(8'h7F, 0, NONE));
    tab.push_back(row(8'h80, 0, NONE));
    for (int i = 0; i < 6; i++) tab.push_back(row(8'h00, 0, NONE));
    tab.push_back(row(8'h05, 1,
                      {KIND_ERROR, 1'b1, 4'h1, 1'b0, 32'hFFFF_FFFF, 8'h00, 1'b0}));
    for (int i = 0; i < 16; i++) tab.push_back(row(8'($urandom), 0, NONE));
    walk_tab();
    frames++;

    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    fail_cnt += want_q.size();

    $display("Sent %0d bytes in %0d frames over five max_payload settings,", sent, frames);
    $display("checked %0d requests, oversize error last, %0d failures.", checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
